/* src/siam_pkg.sv */
package siam_pkg;

  localparam logic [1:0] FUNC_MAP   = 2'd0;
  localparam logic [1:0] FUNC_UNMAP = 2'd1;
  localparam logic [1:0] FUNC_LOAD  = 2'd2;
  localparam logic [1:0] FUNC_STORE = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_ID      = 3'd1;
  localparam logic [2:0] ST_TOO_LARGE  = 3'd2;
  localparam logic [2:0] ST_RANGE      = 3'd3;
  localparam logic [2:0] ST_STACK_FULL = 3'd4;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  seg_id;
    logic [9:0]  offset;
    logic [10:0] word_count;
    logic [31:0] value;
  } in_t;

  typedef struct packed {
    logic [7:0]  new_id;
    logic [31:0] read_data;
    logic [2:0]  status;
  } out_t;

endpackage

/* src/siam_ram.sv */
module siam_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/segment_id_allocator_memory.sv */
// Segmented word memory with a stack of free segment identifiers.
// Requests arrive on in_data (map, unmap, load, store) with in_valid/in_stall;
// every request gives exactly one response on out_data with out_valid/out_stall.
// A request is taken only while idle or as the previous response is loaded
// into the output register, so the block works on one request at a time.
// Unmap, store and any refused request go from the lookup straight to the
// response state; a load does the lookup of the segment length, then the
// word read; a successful map zero-fills its segment, writing one word
// a cycle through the single write port of the word memory.
// The output register is loaded from the response state once it is free.
// When the receiver stalls, the response waits in the output register; one
// further request is still taken and worked on, then waits in the response
// state, and in_stall stays high until the output register is transferred.
// After reset the free stack is empty, segment 0 is mapped with the full
// segment length and the next fresh identifier is 1. The word, length and
// stack memories are not cleared; no clearing pass is needed, and words of
// segment 0 must be stored before they are loaded.
module segment_id_allocator_memory #(
  parameter int MAX_SEGMENTS  = 256,
  parameter int SEGMENT_WORDS = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  siam_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output siam_pkg::out_t  out_data
);

  import siam_pkg::*;

  localparam int ID_W     = $clog2(MAX_SEGMENTS);
  localparam int OFF_W    = (SEGMENT_WORDS > 1) ? $clog2(SEGMENT_WORDS) : 1;
  localparam int LEN_W    = $clog2(SEGMENT_WORDS + 1);
  localparam int CNT_W    = $clog2(MAX_SEGMENTS + 1);
  localparam int DM_DEPTH = MAX_SEGMENTS << OFF_W;
  localparam int DM_AW    = ID_W + OFF_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_FILL = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] free_r, free_nxt;
  logic [CNT_W-1:0] fresh_r, fresh_nxt;
  logic             seg0_set_r, seg0_set_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;
  out_t             res_r, res_nxt;
  in_t              req_r, req_nxt;
  logic [ID_W-1:0]  got_r, got_nxt;
  logic [LEN_W-1:0] fill_r, fill_nxt;

  logic             accept;
  logic             out_free;
  logic [CNT_W-1:0] free_dec;
  logic [LEN_W-1:0] seg_len;
  logic [LEN_W-1:0] fill_inc;

  logic             dm_we;
  logic [DM_AW-1:0] dm_waddr;
  logic [31:0]      dm_wdata;
  logic             dm_re;
  logic [DM_AW-1:0] dm_raddr;
  logic [31:0]      dm_rdata;

  logic             len_we;
  logic [ID_W-1:0]  len_waddr;
  logic [LEN_W-1:0] len_wdata;
  logic [ID_W-1:0]  len_raddr;
  logic [LEN_W-1:0] len_rdata;

  logic             fs_we;
  logic [ID_W-1:0]  fs_waddr;
  logic [ID_W-1:0]  fs_wdata;
  logic [ID_W-1:0]  fs_raddr;
  logic [ID_W-1:0]  fs_rdata;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) || ((state_r == S_RESP) && out_free));
  assign accept   = in_valid && !in_stall;
  assign free_dec = free_r - CNT_W'(1);
  assign fill_inc = fill_r + LEN_W'(1);

  // Length and stack top are looked up as the request is transferred.
  assign len_raddr = ID_W'(in_data.seg_id);
  assign fs_raddr  = free_dec[ID_W-1:0];

  // Segment 0 holds the full length until a map writes its entry.
  assign seg_len = ((req_r.seg_id == '0) && !seg0_set_r) ? LEN_W'(SEGMENT_WORDS) : len_rdata;

  always_comb begin
    state_nxt     = state_r;
    free_nxt      = free_r;
    fresh_nxt     = fresh_r;
    seg0_set_nxt  = seg0_set_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    res_nxt       = res_r;
    req_nxt       = req_r;
    got_nxt       = got_r;
    fill_nxt      = fill_r;

    dm_we     = 1'b0;
    dm_waddr  = {got_r, fill_r[OFF_W-1:0]};
    dm_wdata  = '0;
    dm_re     = 1'b0;
    dm_raddr  = {ID_W'(req_r.seg_id), OFF_W'(req_r.offset)};
    len_we    = 1'b0;
    len_waddr = got_r;
    len_wdata = LEN_W'(req_r.word_count);
    fs_we     = 1'b0;
    fs_waddr  = free_r[ID_W-1:0];
    fs_wdata  = ID_W'(req_r.seg_id);

    if (accept) begin
      req_nxt   = in_data;
      state_nxt = S_LOOK;
    end

    unique case (state_r)
      S_IDLE: begin
      end
      S_LOOK: begin
        res_nxt   = '0;
        state_nxt = S_RESP;
        unique case (req_r.func)
          FUNC_MAP: begin
            if (32'(req_r.word_count) > SEGMENT_WORDS) begin
              res_nxt.status = ST_TOO_LARGE;
            end else if ((free_r == '0) && (32'(fresh_r) >= MAX_SEGMENTS)) begin
              res_nxt.status = ST_NO_ID;
            end else begin
              if (free_r != '0) begin
                got_nxt  = fs_rdata;
                free_nxt = free_dec;
              end else begin
                got_nxt   = fresh_r[ID_W-1:0];
                fresh_nxt = fresh_r + CNT_W'(1);
              end
              len_we         = 1'b1;
              len_waddr      = got_nxt;
              res_nxt.new_id = 8'(got_nxt);
              if (got_nxt == '0) begin
                seg0_set_nxt = 1'b1;
              end
              fill_nxt = '0;
              if (req_r.word_count != '0) begin
                state_nxt = S_FILL;
              end
            end
          end
          FUNC_UNMAP: begin
            if (32'(req_r.seg_id) >= 32'(fresh_r)) begin
              res_nxt.status = ST_RANGE;
            end else if (32'(free_r) >= MAX_SEGMENTS) begin
              res_nxt.status = ST_STACK_FULL;
            end else begin
              fs_we    = 1'b1;
              free_nxt = free_r + CNT_W'(1);
            end
          end
          FUNC_LOAD: begin
            if ((32'(req_r.seg_id) < 32'(fresh_r)) &&
                (32'(req_r.offset) < 32'(seg_len))) begin
              dm_re     = 1'b1;
              state_nxt = S_READ;
            end else begin
              res_nxt.status = ST_RANGE;
            end
          end
          FUNC_STORE: begin
            if ((32'(req_r.seg_id) < 32'(fresh_r)) &&
                (32'(req_r.offset) < 32'(seg_len))) begin
              dm_we    = 1'b1;
              dm_waddr = {ID_W'(req_r.seg_id), OFF_W'(req_r.offset)};
              dm_wdata = req_r.value;
            end else begin
              res_nxt.status = ST_RANGE;
            end
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end
      S_READ: begin
        res_nxt.read_data = dm_rdata;
        state_nxt         = S_RESP;
      end
      S_FILL: begin
        dm_we = 1'b1;
        if (fill_inc == LEN_W'(req_r.word_count)) begin
          state_nxt = S_RESP;
        end else begin
          fill_nxt = fill_inc;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          if (!accept) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_r      <= '0;
      fresh_r     <= CNT_W'(1);
      seg0_set_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_r      <= free_nxt;
      fresh_r     <= fresh_nxt;
      seg0_set_r  <= seg0_set_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r  <= out_nxt;
    res_r  <= res_nxt;
    req_r  <= req_nxt;
    got_r  <= got_nxt;
    fill_r <= fill_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  siam_ram #(
    .WIDTH (32),
    .DEPTH (DM_DEPTH)
  ) u_word_ram (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .re    (dm_re),
    .raddr (dm_raddr),
    .rdata (dm_rdata)
  );

  siam_ram #(
    .WIDTH (LEN_W),
    .DEPTH (MAX_SEGMENTS)
  ) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (len_wdata),
    .re    (accept),
    .raddr (len_raddr),
    .rdata (len_rdata)
  );

  siam_ram #(
    .WIDTH (ID_W),
    .DEPTH (MAX_SEGMENTS)
  ) u_free_ram (
    .clk   (clk),
    .we    (fs_we),
    .waddr (fs_waddr),
    .wdata (fs_wdata),
    .re    (accept),
    .raddr (fs_raddr),
    .rdata (fs_rdata)
  );

  a_resp_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("response loaded outside the response state");

  a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_LOOK))
    else $error("transferred request did not start its lookup");

  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(free_r) <= MAX_SEGMENTS) && (fresh_r != '0) && (32'(fresh_r) <= MAX_SEGMENTS))
    else $error("identifier counters out of range");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL) |-> (fill_r < LEN_W'(req_r.word_count)))
    else $error("zero fill ran past the segment length");

  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    dm_we |-> ((state_r == S_FILL) || (state_r == S_LOOK)))
    else $error("word memory written while no request is being served");

endmodule

/* dv/segment_id_allocator_memory_tb.sv */
`timescale 1ns / 100ps

module segment_id_allocator_memory_tb;
  import siam_pkg::*;

  localparam int MAX_SEG      = 256;
  localparam int SEG_WORDS    = 1024;
  localparam int N_RANDOM     = 1800;
  localparam int BLOCK_LEN    = 100;
  localparam int CYCLE_LIMIT  = 8_000_000;
  localparam int HOLD_START   = 6000;
  localparam int HOLD_LEN     = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int RESET_CYCLES = 11;

  typedef enum logic [1:0] {TR_MIXED, TR_MAP_HEAVY, TR_UNMAP_HEAVY} traffic_t;
  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  typedef struct {
    in_t  req;
    bit   typed;
    out_t resp;
  } dir_row_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  // Mirror of the segmented memory.
  logic [31:0] word_mem   [0:MAX_SEG*SEG_WORDS-1];
  bit          word_set   [0:MAX_SEG*SEG_WORDS-1];
  logic [10:0] seg_len    [0:MAX_SEG-1];
  logic [7:0]  free_stack [0:MAX_SEG-1];
  logic [8:0]  free_cnt   = '0;
  logic [8:0]  fresh_next = 9'd1;

  out_t     answers_due[$];
  dir_row_t dir_tab[$];

  int       op_seen[4];
  int       status_seen[8];
  int       err_cnt       = 0;
  int       item_idx      = 0;
  int       n_taken       = 0;
  bit       stim_done     = 1'b0;
  bit       cur_typed     = 1'b0;
  out_t     cur_resp      = '0;
  int       burst_left    = 0;
  int       gap_left      = 0;
  int       rx_cyc        = 0;
  int       rx_phase_left = 0;
  rx_mode_t rx_mode       = RX_OPEN;

  segment_id_allocator_memory i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  function automatic int word_addr(logic [7:0] id, logic [9:0] off);
    return int'({id, off});
  endfunction

  function automatic bit addr_hit(logic [7:0] id, logic [9:0] off);
    return (9'(id) < fresh_next) && (11'(off) < seg_len[id]);
  endfunction

  // Applies one request to the mirror and returns the response it must give.
  function automatic out_t run_request(in_t r);
    out_t       o;
    logic [7:0] got;
    bit         have;
    o    = '0;
    got  = '0;
    have = 1'b0;
    case (r.func)
      FUNC_MAP: begin
        if (r.word_count > SEG_WORDS) begin
          o.status = ST_TOO_LARGE;
        end else if (free_cnt > 0) begin
          free_cnt = free_cnt - 9'd1;
          got      = free_stack[free_cnt];
          have     = 1'b1;
        end else if (fresh_next < MAX_SEG) begin
          got        = fresh_next[7:0];
          fresh_next = fresh_next + 9'd1;
          have       = 1'b1;
        end else begin
          o.status = ST_NO_ID;
        end
        if (have) begin
          for (int i = 0; i < int'(r.word_count); i++) begin
            word_mem[word_addr(got, 10'(i))] = '0;
            word_set[word_addr(got, 10'(i))] = 1'b1;
          end
          seg_len[got] = r.word_count;
          o.new_id     = got;
        end
      end
      FUNC_UNMAP: begin
        if (9'(r.seg_id) >= fresh_next) begin
          o.status = ST_RANGE;
        end else if (free_cnt >= MAX_SEG) begin
          o.status = ST_STACK_FULL;
        end else begin
          free_stack[free_cnt] = r.seg_id;
          free_cnt             = free_cnt + 9'd1;
        end
      end
      FUNC_LOAD: begin
        if (addr_hit(r.seg_id, r.offset)) begin
          o.read_data = word_mem[word_addr(r.seg_id, r.offset)];
        end else begin
          o.status = ST_RANGE;
        end
      end
      default: begin
        if (addr_hit(r.seg_id, r.offset)) begin
          word_mem[word_addr(r.seg_id, r.offset)] = r.value;
          word_set[word_addr(r.seg_id, r.offset)] = 1'b1;
        end else begin
          o.status = ST_RANGE;
        end
      end
    endcase
    op_seen[r.func]++;
    status_seen[o.status]++;
    return o;
  endfunction

  function automatic traffic_t block_mode(int blk);
    if (blk >= 3 && blk <= 6) return TR_MAP_HEAVY;
    if (blk >= 8 && blk <= 11) return TR_UNMAP_HEAVY;
    if (blk == 13 || blk == 14) return TR_MAP_HEAVY;
    return TR_MIXED;
  endfunction

  function automatic in_t make_request(traffic_t mode);
    in_t         r;
    int          p;
    int          q;
    logic [10:0] len;
    // Fields that the operation ignores still carry random values.
    r.seg_id     = 8'($urandom);
    r.offset     = 10'($urandom);
    r.word_count = 11'($urandom);
    r.value      = $urandom;
    p = $urandom_range(0, 99);
    case (mode)
      TR_MAP_HEAVY:   r.func = (p < 85) ? FUNC_MAP : (p < 93) ? FUNC_LOAD : FUNC_STORE;
      TR_UNMAP_HEAVY: r.func = (p < 90) ? FUNC_UNMAP : (p < 95) ? FUNC_LOAD : FUNC_STORE;
      default: begin
        r.func = (p < 12) ? FUNC_MAP : (p < 22) ? FUNC_UNMAP :
                 (p < 61) ? FUNC_LOAD : FUNC_STORE;
      end
    endcase
    q = $urandom_range(0, 99);
    case (r.func)
      FUNC_MAP: begin
        // Most segments are small so that the zero fill stays short.
        if (q < 3) r.word_count = 11'($urandom_range(SEG_WORDS + 1, 2047));
        else if (q < 6) r.word_count = 11'(SEG_WORDS);
        else if (q < 12) r.word_count = 11'($urandom_range(17, SEG_WORDS - 1));
        else r.word_count = 11'($urandom_range(0, 16));
      end
      FUNC_UNMAP: begin
        if (q < 90) r.seg_id = 8'($urandom_range(0, int'(fresh_next) - 1));
      end
      default: begin
        if (q < 80) begin
          r.seg_id = 8'($urandom_range(0, int'(fresh_next) - 1));
        end else if (q < 90 && fresh_next < MAX_SEG) begin
          r.seg_id = 8'($urandom_range(int'(fresh_next), MAX_SEG - 1));
        end
        len = (9'(r.seg_id) < fresh_next) ? seg_len[r.seg_id] : 11'd0;
        q   = $urandom_range(0, 99);
        if (q < 85 && len > 0) r.offset = 10'($urandom_range(0, int'(len) - 1));
        else if (q < 92 && len < SEG_WORDS) r.offset = len[9:0];
        q = $urandom_range(0, 19);
        if (q == 0) r.value = '0;
        else if (q == 1) r.value = '1;
        // Program words of segment zero that were never stored must not be read.
        if (r.func == FUNC_LOAD && addr_hit(r.seg_id, r.offset) &&
            !word_set[word_addr(r.seg_id, r.offset)]) begin
          r.func = FUNC_STORE;
        end
      end
    endcase
    return r;
  endfunction

  task automatic add_row(in_t req, bit typed, out_t resp);
    dir_row_t row;
    row.req   = req;
    row.typed = typed;
    row.resp  = resp;
    dir_tab.push_back(row);
  endtask

  // Sender, predictor and response check share one process so that the
  // mirror is up to date before the next request is chosen.
  always @(posedge clk) begin : sender_p
    out_t want;
    out_t pred;
    in_t  nxt;
    int   ridx;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pred = run_request(in_data);
        answers_due.push_back(cur_typed ? cur_resp : pred);
        n_taken++;
      end
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          err_cnt++;
          $display("%0t: response with none outstanding: new_id=%0d read_data=%h status=%0d",
                   $time, out_data.new_id, out_data.read_data, out_data.status);
        end else begin
          want = answers_due.pop_front();
          if (out_data.new_id !== want.new_id || out_data.read_data !== want.read_data ||
              out_data.status !== want.status) begin
            err_cnt++;
            $display("%0t: mismatch: expected %0d/%h/%0d, got %0d/%h/%0d",
                     $time, want.new_id, want.read_data, want.status,
                     out_data.new_id, out_data.read_data, out_data.status);
          end
        end
      end
      if (!in_valid || !in_stall) begin
        if (item_idx >= dir_tab.size() + N_RANDOM) begin
          in_valid  <= 1'b0;
          stim_done = 1'b1;
        end else if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else begin
          if (item_idx < dir_tab.size()) begin
            nxt       = dir_tab[item_idx].req;
            cur_typed = dir_tab[item_idx].typed;
            cur_resp  = dir_tab[item_idx].resp;
          end else begin
            ridx      = item_idx - dir_tab.size();
            nxt       = make_request(block_mode(ridx / BLOCK_LEN));
            cur_typed = 1'b0;
          end
          in_data  <= nxt;
          in_valid <= 1'b1;
          item_idx++;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // Receiver: stall phases of random kind and length, with one long hold-off
  // during which the block must refuse further requests.
  always @(posedge clk) begin : receiver_p
    rx_cyc++;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (rx_cyc >= HOLD_START && rx_cyc < HOLD_START + HOLD_LEN) begin
      out_stall <= 1'b1;
    end else begin
      if (rx_phase_left <= 0) begin
        rx_mode       = rx_mode_t'($urandom_range(0, 3));
        rx_phase_left = $urandom_range(32, 256);
      end
      rx_phase_left--;
      case (rx_mode)
        RX_OPEN:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= ~out_stall;
      endcase
    end
  end

  initial begin : watchdog_p
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL segment_id_allocator_memory");
    $finish;
  end

  initial begin : main_p
    seg_len[0] = 11'(SEG_WORDS);
    add_row('{FUNC_STORE, 8'd0, 10'd0, 11'd0, 32'hFFFF_FFFF}, 1'b0, '0);
    add_row('{FUNC_LOAD, 8'd0, 10'd0, 11'd0, 32'd0}, 1'b1, '{8'd0, 32'hFFFF_FFFF, ST_OK});
    add_row('{FUNC_STORE, 8'd0, 10'd1023, 11'd0, 32'h5A5A_0001}, 1'b0, '0);
    add_row('{FUNC_LOAD, 8'd1, 10'd0, 11'd0, 32'hFFFF_FFFF}, 1'b1, '{8'd0, 32'd0, ST_RANGE});
    add_row('{FUNC_STORE, 8'd255, 10'd1023, 11'd2047, 32'hFFFF_FFFF}, 1'b1,
            '{8'd0, 32'd0, ST_RANGE});
    add_row('{FUNC_UNMAP, 8'd255, 10'd0, 11'd0, 32'd0}, 1'b1, '{8'd0, 32'd0, ST_RANGE});
    add_row('{FUNC_MAP, 8'd0, 10'd0, 11'd1025, 32'd0}, 1'b1, '{8'd0, 32'd0, ST_TOO_LARGE});
    add_row('{FUNC_MAP, 8'd255, 10'd1023, 11'd2047, 32'hFFFF_FFFF}, 1'b1,
            '{8'd0, 32'd0, ST_TOO_LARGE});
    add_row('{FUNC_MAP, 8'd0, 10'd0, 11'd1024, 32'd0}, 1'b1, '{8'd1, 32'd0, ST_OK});
    add_row('{FUNC_LOAD, 8'd1, 10'd1023, 11'd0, 32'd0}, 1'b0, '0);
    add_row('{FUNC_MAP, 8'd0, 10'd0, 11'd0, 32'd0}, 1'b0, '0);
    add_row('{FUNC_LOAD, 8'd2, 10'd0, 11'd0, 32'd0}, 1'b1, '{8'd0, 32'd0, ST_RANGE});
    add_row('{FUNC_STORE, 8'd1, 10'd512, 11'd0, 32'hA5A5_A5A5}, 1'b0, '0);
    add_row('{FUNC_UNMAP, 8'd1, 10'd0, 11'd0, 32'd0}, 1'b0, '0);
    // An unmapped segment stays readable until it is mapped again.
    add_row('{FUNC_LOAD, 8'd1, 10'd512, 11'd0, 32'd0}, 1'b0, '0);
    add_row('{FUNC_UNMAP, 8'd2, 10'd0, 11'd0, 32'd0}, 1'b0, '0);
    add_row('{FUNC_UNMAP, 8'd2, 10'd0, 11'd0, 32'd0}, 1'b0, '0);
    add_row('{FUNC_MAP, 8'd0, 10'd0, 11'd4, 32'd0}, 1'b0, '0);
    add_row('{FUNC_MAP, 8'd0, 10'd0, 11'd4, 32'd0}, 1'b0, '0);
    add_row('{FUNC_MAP, 8'd0, 10'd0, 11'd8, 32'd0}, 1'b0, '0);
    add_row('{FUNC_LOAD, 8'd1, 10'd512, 11'd0, 32'd0}, 1'b0, '0);
    add_row('{FUNC_STORE, 8'd1, 10'd8, 11'd0, 32'h1234_5678}, 1'b0, '0);
    add_row('{FUNC_LOAD, 8'd0, 10'd1023, 11'd0, 32'd0}, 1'b0, '0);
    add_row('{FUNC_UNMAP, 8'd0, 10'd0, 11'd0, 32'd0}, 1'b0, '0);
    add_row('{FUNC_MAP, 8'd0, 10'd0, 11'd1, 32'd0}, 1'b0, '0);
    add_row('{FUNC_LOAD, 8'd0, 10'd0, 11'd0, 32'd0}, 1'b0, '0);
    add_row('{FUNC_LOAD, 8'd0, 10'd1, 11'd0, 32'd0}, 1'b0, '0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    wait (stim_done);
    while (answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests: %0d map, %0d unmap, %0d load, %0d store.",
             n_taken, op_seen[FUNC_MAP], op_seen[FUNC_UNMAP], op_seen[FUNC_LOAD],
             op_seen[FUNC_STORE]);
    $display("Responses by status: ok %0d, no id %0d, too large %0d, range %0d, stack full %0d.",
             status_seen[ST_OK], status_seen[ST_NO_ID], status_seen[ST_TOO_LARGE],
             status_seen[ST_RANGE], status_seen[ST_STACK_FULL]);
    if (err_cnt == 0 && answers_due.size() == 0) begin
      $display("PASS segment_id_allocator_memory");
    end else begin
      $display("FAIL segment_id_allocator_memory");
    end
    $finish;
  end

endmodule

/* segment_id_allocator_memory.f */
src/siam_pkg.sv
src/siam_ram.sv
src/segment_id_allocator_memory.sv
dv/segment_id_allocator_memory_tb.sv
